>>> rtl/core/aes256_cbc_encrypt_with_mix_top_assert.svh
// Assertion macros shared by the AES-256 CBC block.
`ifndef AES256_CBC_ENCRYPT_WITH_MIX_TOP_ASSERT_SVH
`define AES256_CBC_ENCRYPT_WITH_MIX_TOP_ASSERT_SVH
// Checks a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
// Checks that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> rtl/core/aescbc_pkg.sv
// Shared constants, types and AES functions of the AES-256 CBC block.
`timescale 1ns / 1ps
`default_nettype none
package aescbc_pkg;
   localparam int unsigned BlockWidth  = 128;
   localparam int unsigned KeyWidth    = 256;
   localparam int unsigned NumRoundKey = 15;
   localparam int unsigned LastRound   = NumRoundKey - 1;
   localparam int unsigned RoundWidth  = $clog2(NumRoundKey);
   localparam int unsigned CsrIdxWidth = 3;

   localparam logic [CsrIdxWidth-1:0] CSR_KEY_W0  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY_W1  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY_W2  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY_W3  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_IV_LOW  = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_IV_HIGH = 3'd5;

   typedef logic [BlockWidth-1:0] block_type;

   typedef struct packed {
      logic busy;
   } key_status_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] tab [256];
      tab = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
      };
      return tab[x];
   endfunction

   // Round constant for every eighth key word; the unused slot reads as zero.
   function automatic logic [7:0] rcon(input logic [2:0] idx);
      logic [7:0] val;
      unique case (idx)
         3'd0: val = 8'h01;
         3'd1: val = 8'h02;
         3'd2: val = 8'h04;
         3'd3: val = 8'h08;
         3'd4: val = 8'h10;
         3'd5: val = 8'h20;
         3'd6: val = 8'h40;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // SubBytes and ShiftRows, then MixColumns unless this is the final round.
   function automatic block_type aes_round(input block_type s, input logic last);
      block_type t;
      block_type m;
      logic [7:0] a0, a1, a2, a3, all;
      for (int col = 0; col < 4; col++) begin
         for (int row = 0; row < 4; row++) begin
            t[8*(row+4*col) +: 8] = sbox(s[8*(row + 4*((col + row) % 4)) +: 8]);
         end
      end
      for (int col = 0; col < 4; col++) begin
         a0  = t[8*(4*col)   +: 8];
         a1  = t[8*(4*col+1) +: 8];
         a2  = t[8*(4*col+2) +: 8];
         a3  = t[8*(4*col+3) +: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         m[8*(4*col)   +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         m[8*(4*col+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         m[8*(4*col+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         m[8*(4*col+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return last ? t : m;
   endfunction
endpackage
`default_nettype wire

>>> rtl/core/aescbc_key_mem.sv
// Round key expansion sequencer and the round key memory.
`timescale 1ns / 1ps
`default_nettype none
module aescbc_key_mem
   import aescbc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [KeyWidth-1:0]   key,
   input  wire logic [RoundWidth-1:0] rd_addr,
   output block_type                  rd_data,
   output key_status_type             status
);
   block_type             mem [NumRoundKey];
   block_type             rd_data_ff;
   block_type             prev2_ff, prev2_in;
   block_type             prev1_ff, prev1_in;
   block_type             next_key;
   logic [RoundWidth-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic [31:0]           temp;
   logic [31:0]           last_word;

   // Round key cnt+2 from the two keys before it.
   always_comb begin
      last_word = prev1_ff[127:96];
      if (!cnt_ff[0]) begin
         temp = {sbox(last_word[7:0]), sbox(last_word[31:24]),
                 sbox(last_word[23:16]), sbox(last_word[15:8]) ^ rcon(cnt_ff[3:1])};
      end else begin
         temp = {sbox(last_word[31:24]), sbox(last_word[23:16]),
                 sbox(last_word[15:8]), sbox(last_word[7:0])};
      end
      next_key[31:0]   = prev2_ff[31:0]   ^ temp;
      next_key[63:32]  = prev2_ff[63:32]  ^ next_key[31:0];
      next_key[95:64]  = prev2_ff[95:64]  ^ next_key[63:32];
      next_key[127:96] = prev2_ff[127:96] ^ next_key[95:64];
   end

   always_comb begin
      prev2_in = prev2_ff;
      prev1_in = prev1_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      if (start) begin
         prev2_in = key[BlockWidth-1:0];
         prev1_in = key[KeyWidth-1:BlockWidth];
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         prev2_in = prev1_ff;
         prev1_in = next_key;
         cnt_in   = cnt_ff + 1'b1;
         busy_in  = (cnt_ff != RoundWidth'(LastRound));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         busy_ff  <= 1'b1;
         prev2_ff <= '0;
         prev1_ff <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         busy_ff  <= busy_in;
         prev2_ff <= prev2_in;
         prev1_ff <= prev1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && !start && !reset) begin
         mem[cnt_ff] <= prev2_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data     = rd_data_ff;
   assign status.busy = busy_ff;
endmodule
`default_nettype wire

>>> rtl/core/aescbc_cipher.sv
// Round sequencer, state register, chaining value and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "aes256_cbc_encrypt_with_mix_top_assert.svh"
module aescbc_cipher
   import aescbc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire block_type             in_block,
   input  wire logic                  in_restart,
   input  wire block_type             iv,
   input  wire key_status_type        key_status,
   output logic [RoundWidth-1:0]      rk_addr,
   input  wire block_type             rk_data,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output block_type                  out_block
);
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type             st_ff, st_in;
   logic [RoundWidth-1:0] rnd_ff, rnd_in;
   block_type             s_ff, s_in;
   block_type             chain_ff, chain_in;
   block_type             out_ff, out_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  accept;
   logic                  out_free;
   logic                  final_rnd;
   block_type             round_out;

   assign in_ready  = (st_ff == ST_IDLE) && !key_status.busy;
   assign accept    = in_valid && in_ready;
   assign out_free  = !out_valid_ff || out_ready;
   assign final_rnd = (rnd_ff == RoundWidth'(LastRound));
   assign round_out = aes_round(s_ff, final_rnd) ^ rk_data;

   always_comb begin
      st_in        = st_ff;
      rnd_in       = rnd_ff;
      s_in         = s_ff;
      chain_in     = chain_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !out_ready;
      rk_addr      = '0;
      unique case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               s_in   = in_block ^ (in_restart ? iv : chain_ff);
               rnd_in = '0;
               st_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            if (rnd_ff == '0) begin
               s_in    = s_ff ^ rk_data;
               rnd_in  = rnd_ff + 1'b1;
               rk_addr = rnd_in;
            end else if (!final_rnd) begin
               s_in    = round_out;
               rnd_in  = rnd_ff + 1'b1;
               rk_addr = rnd_in;
            end else begin
               // The last round waits here with its key held until the result
               // register can take the ciphertext.
               rk_addr = rnd_ff;
               if (out_free) begin
                  out_in       = round_out;
                  chain_in     = round_out;
                  out_valid_in = 1'b1;
                  st_in        = ST_IDLE;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rnd_ff       <= '0;
         out_valid_ff <= 1'b0;
         chain_ff     <= '0;
      end else begin
         st_ff        <= st_in;
         rnd_ff       <= rnd_in;
         out_valid_ff <= out_valid_in;
         chain_ff     <= chain_in;
      end
      s_ff   <= s_in;
      out_ff <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_block = out_ff;

   `ASSERT_ALWAYS(no_accept_in_expand, !(accept && key_status.busy), "accept during key expansion")
   `ASSERT_ALWAYS(round_in_range, rnd_ff <= RoundWidth'(LastRound), "round counter overflow")
   `ASSERT_NEXT(accept_starts_run, accept, (st_ff == ST_RUN) && (rnd_ff == '0), "accept lost")
   `ASSERT_NEXT(finish_sets_valid, (st_ff == ST_RUN) && final_rnd && out_free,
                out_valid_ff && (out_ff == chain_ff), "result and chain disagree")
endmodule
`default_nettype wire

>>> rtl/core/aes256_cbc_encrypt_with_mix_top.sv
// Top level of the AES-256 CBC encryptor with an extra mix block.
`timescale 1ns / 1ps
`default_nettype none
// Usage: each transfer on the req_ channel carries a 128-bit data block and a
// 128-bit mix block in req_tdata and a restart flag in req_tuser. The block
// XORs data, mix and the chaining value (the IV registers when restart is set),
// encrypts the sum with 14-round AES-256 and returns the ciphertext on the rsp_
// channel; the ciphertext becomes the next chaining value.
// After the input transfer the state takes the whitening key and then the
// rounds one at a time, each round key read from the round key memory ahead
// of its use. A new item is taken only once the last round of the current one
// has finished, since the single round unit serves one item at a time.
// Key and IV registers are written on the csr_ port; a key write starts an
// expansion pass into the round key memory, and no item is taken while it
// runs. Reset clears the key, IV and control registers, loads a zero chaining
// value and runs the same expansion of the all-zero key before the first item.
// When the receiver stalls, the finished result waits in the output register
// while the next item is accepted and worked on; that item then holds in its
// last round until the output register is free.
module aes256_cbc_encrypt_with_mix_top
   import aescbc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // data_low, data_high, mix_low, mix_high
   input  wire logic [255:0]           req_tdata,
   // restart
   input  wire logic [0:0]             req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // cipher_low, cipher_high
   output logic [127:0]                rsp_tdata,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [63:0]            csr_data
);
   logic [KeyWidth-1:0]   key_ff, key_in;
   block_type             iv_ff, iv_in;
   logic                  csr_write;
   logic                  key_write;
   key_status_type        key_status;
   logic [RoundWidth-1:0] rk_addr;
   block_type             rk_data;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      key_in    = key_ff;
      iv_in     = iv_ff;
      key_write = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_W0: begin key_in[63:0]    = csr_data; key_write = 1'b1; end
            CSR_KEY_W1: begin key_in[127:64]  = csr_data; key_write = 1'b1; end
            CSR_KEY_W2: begin key_in[191:128] = csr_data; key_write = 1'b1; end
            CSR_KEY_W3: begin key_in[255:192] = csr_data; key_write = 1'b1; end
            CSR_IV_LOW:  iv_in[63:0]   = csr_data;
            CSR_IV_HIGH: iv_in[127:64] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         iv_ff  <= '0;
      end else begin
         key_ff <= key_in;
         iv_ff  <= iv_in;
      end
   end

   aescbc_key_mem u_key_mem (
      .clock   (clock),
      .reset   (reset),
      .start   (key_write),
      .key     (key_in),
      .rd_addr (rk_addr),
      .rd_data (rk_data),
      .status  (key_status)
   );

   aescbc_cipher u_cipher (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_block   (req_tdata[127:0] ^ req_tdata[255:128]),
      .in_restart (req_tuser[0]),
      .iv         (iv_ff),
      .key_status (key_status),
      .rk_addr    (rk_addr),
      .rk_data    (rk_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_block  (rsp_tdata)
   );
endmodule
`default_nettype wire

>>> tb/sv/aes256_cbc_encrypt_with_mix_checker.sv
// Checker that predicts AES-256 CBC ciphertexts and compares them with the rsp_ channel.
`timescale 1ns / 1ps
module aes256_cbc_encrypt_with_mix_checker
   import aescbc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [255:0]           req_tdata,
   input  logic [0:0]             req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [127:0]           rsp_tdata,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [63:0]            csr_data,
   output int unsigned            mismatch_count,
   output int unsigned            cipher_backlog
);
   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   logic [63:0]  key_word [4];
   logic [127:0] iv_value;
   logic [127:0] chain_value;
   logic [127:0] round_key [15];
   logic [127:0] cipher_expected [$];

   function automatic logic [7:0] gf_double(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic void rebuild_round_keys();
      logic [7:0] w [240];
      logic [7:0] t [4];
      logic [7:0] r0;
      logic [7:0] rc;
      int i, j;
      for (i = 0; i < 32; i++) w[i] = key_word[i / 8][8 * (i % 8) +: 8];
      rc = 8'h01;
      for (i = 8; i < 60; i++) begin
         for (j = 0; j < 4; j++) t[j] = w[4 * (i - 1) + j];
         if (i % 8 == 0) begin
            r0 = t[0];
            t[0] = SBOX[t[1]] ^ rc;
            t[1] = SBOX[t[2]];
            t[2] = SBOX[t[3]];
            t[3] = SBOX[r0];
            rc = gf_double(rc);
         end else if (i % 8 == 4) begin
            for (j = 0; j < 4; j++) t[j] = SBOX[t[j]];
         end
         for (j = 0; j < 4; j++) w[4 * i + j] = w[4 * (i - 8) + j] ^ t[j];
      end
      for (i = 0; i < 15; i++)
         for (j = 0; j < 16; j++) round_key[i][8 * j +: 8] = w[16 * i + j];
   endfunction

   // Byte n of the state sits in bits 8n+7:8n; column c holds bytes 4c..4c+3.
   function automatic logic [127:0] cbc_cipher_block(input logic [127:0] plain);
      logic [127:0] s, t;
      logic [7:0] a0, a1, a2, a3, sum;
      int r, row, col;
      s = plain ^ round_key[0];
      for (r = 1; r <= 14; r++) begin
         for (col = 0; col < 4; col++)
            for (row = 0; row < 4; row++)
               t[8 * (row + 4 * col) +: 8] = SBOX[s[8 * (row + 4 * ((col + row) % 4)) +: 8]];
         if (r != 14) begin
            for (col = 0; col < 4; col++) begin
               a0 = t[32 * col +: 8];
               a1 = t[32 * col + 8 +: 8];
               a2 = t[32 * col + 16 +: 8];
               a3 = t[32 * col + 24 +: 8];
               sum = a0 ^ a1 ^ a2 ^ a3;
               t[32 * col +: 8]      = a0 ^ sum ^ gf_double(a0 ^ a1);
               t[32 * col + 8 +: 8]  = a1 ^ sum ^ gf_double(a1 ^ a2);
               t[32 * col + 16 +: 8] = a2 ^ sum ^ gf_double(a2 ^ a3);
               t[32 * col + 24 +: 8] = a3 ^ sum ^ gf_double(a3 ^ a0);
            end
         end
         s = t ^ round_key[r];
      end
      return s;
   endfunction

   assign cipher_backlog = cipher_expected.size();

   always @(posedge clock) begin
      logic [127:0] got, want;
      if (reset) begin
         for (int k = 0; k < 4; k++) key_word[k] = '0;
         iv_value = '0;
         chain_value = '0;
         mismatch_count = 0;
         cipher_expected.delete();
         rebuild_round_keys();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEY_W0, CSR_KEY_W1, CSR_KEY_W2, CSR_KEY_W3: begin
                  key_word[csr_index] = csr_data;
                  rebuild_round_keys();
               end
               CSR_IV_LOW:  iv_value[63:0] = csr_data;
               CSR_IV_HIGH: iv_value[127:64] = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0]) chain_value = iv_value;
            chain_value = cbc_cipher_block(req_tdata[127:0] ^ req_tdata[255:128] ^ chain_value);
            cipher_expected.push_back(chain_value);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (cipher_expected.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected ciphertext %h", $time, got);
            end else begin
               want = cipher_expected.pop_front();
               if (got[63:0] !== want[63:0]) begin
                  mismatch_count++;
                  $display("%0t: cipher_low expected %h actual %h", $time, want[63:0],
                           got[63:0]);
               end
               if (got[127:64] !== want[127:64]) begin
                  mismatch_count++;
                  $display("%0t: cipher_high expected %h actual %h", $time, want[127:64],
                           got[127:64]);
               end
            end
         end
      end
   end
endmodule

>>> tb/sv/aes256_cbc_encrypt_with_mix_top_tb.sv
// Stimulus and verdict for the AES-256 CBC encryptor with an extra mix block.
`timescale 1ns / 1ps
module aes256_cbc_encrypt_with_mix_top_tb;
   import aescbc_pkg::*;

   // Register indexes past the last register; writes to them must be ignored.
   localparam logic [CsrIdxWidth-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CsrIdxWidth-1:0] CSR_SPARE_B = 3'd7;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned DRAIN_CYCLES = 40;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [255:0]           req_tdata;
   logic [0:0]             req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [127:0]           rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [63:0]            csr_data;
   int unsigned            mismatch_count;
   int unsigned            cipher_backlog;

   // Transfer counts on both channels; configuration waits until they agree.
   int unsigned blocks_sent;
   int unsigned blocks_returned;
   int unsigned burst_left;
   int unsigned cycle_count;
   int unsigned stall_left;

   aes256_cbc_encrypt_with_mix_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   aes256_cbc_encrypt_with_mix_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .cipher_backlog (cipher_backlog)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The receiver alternates between ready and stalled stretches of random length,
   // with ready stretches more common and sometimes long enough to run unthrottled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
            stall_left <= $urandom_range(1, 60);
         end else begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(1, 25);
         end
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) blocks_returned <= 0;
      else if (rsp_tvalid && rsp_tready) blocks_returned <= blocks_returned + 1;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Random 64-bit value, weighted toward the all-zero and all-one extremes.
   function automatic logic [63:0] pick_word();
      int unsigned sel;
      sel = $urandom_range(0, 15);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      return rand_word();
   endfunction

   // Holds the block on the request channel until it is taken. Bursts of
   // back-to-back transfers are separated by random gaps with valid low.
   task automatic send_block(input logic [63:0] d_lo, input logic [63:0] d_hi,
                             input logic [63:0] m_lo, input logic [63:0] m_hi,
                             input logic restart);
      req_tvalid <= 1'b1;
      req_tdata  <= {m_hi, m_lo, d_hi, d_lo};
      req_tuser  <= restart;
      do @(posedge clock); while (!req_tready);
      blocks_sent++;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 120)
                                                  : $urandom_range(1, 12);
      end else begin
         burst_left--;
      end
   endtask

   // Valid is driven low after each write, so that it drops between writes.
   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Registers only change once every outstanding ciphertext has come back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (blocks_returned != blocks_sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_blocks(input int unsigned count);
      for (int unsigned n = 0; n < count; n++)
         send_block(pick_word(), pick_word(), pick_word(), pick_word(),
                    $urandom_range(0, 7) == 0);
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_KEY_W0;
      csr_data    = '0;
      cycle_count = 0;
      blocks_sent = 0;
      burst_left  = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the all-zero reset key and zero chaining value.
      send_block('0, '0, '0, '0, 1'b0);
      send_block('1, '1, '0, '0, 1'b0);
      send_block('0, '0, '1, '1, 1'b0);
      send_block('1, '1, '1, '1, 1'b1);
      send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0);
      wait_idle();

      // Standard test key with bytes 00..1f and a nonzero IV.
      write_reg(CSR_KEY_W0, 64'h0706_0504_0302_0100);
      write_reg(CSR_KEY_W1, 64'h0f0e_0d0c_0b0a_0908);
      write_reg(CSR_KEY_W2, 64'h1716_1514_1312_1110);
      write_reg(CSR_KEY_W3, 64'h1f1e_1d1c_1b1a_1918);
      write_reg(CSR_IV_LOW, 64'h0123_4567_89ab_cdef);
      write_reg(CSR_IV_HIGH, 64'hfedc_ba98_7654_3210);
      // The new IV only takes effect at the next restart.
      send_block(64'h7766_5544_3322_1100, 64'hffee_ddcc_bbaa_9988, '0, '0, 1'b0);
      send_block(64'h7766_5544_3322_1100, 64'hffee_ddcc_bbaa_9988, '0, '0, 1'b1);
      send_block('0, '0, 64'h7766_5544_3322_1100, 64'hffee_ddcc_bbaa_9988, 1'b1);
      send_block('1, '0, '0, '1, 1'b0);
      wait_idle();

      // Writes past the last register must leave key and IV untouched.
      write_reg(CSR_SPARE_A, '1);
      write_reg(CSR_SPARE_B, '1);
      send_block('0, '0, '0, '0, 1'b1);
      send_block('1, '1, '1, '1, 1'b0);
      wait_idle();

      // Random phases: all-one key and IV, fully random, back to zero, and
      // partial rewrites that leave some words as they were.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_KEY_W0, '1);
               write_reg(CSR_KEY_W1, '1);
               write_reg(CSR_KEY_W2, '1);
               write_reg(CSR_KEY_W3, '1);
               write_reg(CSR_IV_LOW, '1);
               write_reg(CSR_IV_HIGH, '1);
            end
            2: begin
               write_reg(CSR_KEY_W0, '0);
               write_reg(CSR_KEY_W1, '0);
               write_reg(CSR_KEY_W2, '0);
               write_reg(CSR_KEY_W3, '0);
               write_reg(CSR_IV_LOW, '0);
               write_reg(CSR_IV_HIGH, '0);
            end
            4: begin
               write_reg(CSR_KEY_W2, rand_word());
               write_reg(CSR_IV_HIGH, rand_word());
               write_reg(CSR_SPARE_A, rand_word());
            end
            default: begin
               write_reg(CSR_KEY_W0, rand_word());
               write_reg(CSR_KEY_W1, rand_word());
               write_reg(CSR_KEY_W2, rand_word());
               write_reg(CSR_KEY_W3, rand_word());
               write_reg(CSR_IV_LOW, rand_word());
               write_reg(CSR_IV_HIGH, rand_word());
               write_reg(CSR_SPARE_B, rand_word());
            end
         endcase
         send_block(rand_word(), rand_word(), rand_word(), rand_word(), 1'b1);
         send_random_blocks(199);
         wait_idle();
      end

      if (mismatch_count == 0 && cipher_backlog == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

>>> aes256_cbc_encrypt_with_mix_top.f
+incdir+rtl/core
rtl/core/aescbc_pkg.sv
rtl/core/aescbc_key_mem.sv
rtl/core/aescbc_cipher.sv
rtl/core/aes256_cbc_encrypt_with_mix_top.sv
tb/sv/aes256_cbc_encrypt_with_mix_checker.sv
tb/sv/aes256_cbc_encrypt_with_mix_top_tb.sv
